>>> sv/tlbfl_pkg.sv
// package for the translation buffer: operation kinds and the
// controller-to-datapath command and status structs. no dependencies
`default_nettype none

package tlbfl_pkg;

    localparam logic [1:0] KIND_LOOKUP      = 2'd0;
    localparam logic [1:0] KIND_FILL        = 2'd1;
    localparam logic [1:0] KIND_FLUSH_PID   = 2'd2;
    localparam logic [1:0] KIND_FLUSH_FRAME = 2'd3;

    localparam logic CFG_POLICY_LRU    = 1'b0;
    localparam logic CFG_ENTRIES_LIMIT = 1'b1;

    localparam int LIMIT_BITS  = 5;
    localparam int LIMIT_RESET = 16;

    typedef struct packed {
        logic latch;
        logic match;
        logic update;
        logic flush_step;
    } tlbfl_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic flush_last;
    } tlbfl_stat_t;

endpackage

`default_nettype wire

>>> sv/tlb_with_fifo_lru_replacement.sv
// top level of the fully associative translation buffer with fifo or lru
// replacement; holds the config registers, uses tlbfl_ctrl, tlbfl_dp, tlbfl_pkg
//
// channel   handshake                 payload
// input     start, busy               kind, asid, segment, page, frame_in
// result    done                      hit, frame_out, replaced, used_entries
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// lookup and fill pass through latch, match, update and result from start to done
// flushes step through every entry: one entry is checked, and dropped if it matches, per cycle
// busy is high from the cycle after start until done; done lasts one cycle
// the receiver cannot stall; config is always ready
// reset clears all valid bits, ranks and the count; policy fifo, limit 16
`default_nettype none

module tlb_with_fifo_lru_replacement
    import tlbfl_pkg::*;
#(
    parameter int TLB_DEPTH    = 16,
    parameter int PID_BITS     = 16,
    parameter int SEGMENT_BITS = 8,
    parameter int PAGE_BITS    = 10,
    parameter int FRAME_BITS   = 12,
    localparam int CNT_W       = $clog2(TLB_DEPTH + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              kind,
    input  wire logic [PID_BITS-1:0]     asid,
    input  wire logic [SEGMENT_BITS-1:0] segment,
    input  wire logic [PAGE_BITS-1:0]    page,
    input  wire logic [FRAME_BITS-1:0]   frame_in,
    output logic                         done,
    output logic                         hit,
    output logic [FRAME_BITS-1:0]        frame_out,
    output logic                         replaced,
    output logic [CNT_W-1:0]             used_entries,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic                    cfg_index,
    input  wire logic [LIMIT_BITS-1:0]   cfg_data
);

    logic                  policy_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    tlbfl_cmd_t            cmd;
    tlbfl_stat_t           stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            limit_reg  <= LIMIT_BITS'(LIMIT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_POLICY_LRU:    policy_reg <= cfg_data[0];
                CFG_ENTRIES_LIMIT: limit_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tlbfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    tlbfl_dp #(
        .TLB_DEPTH    (TLB_DEPTH),
        .PID_BITS     (PID_BITS),
        .SEGMENT_BITS (SEGMENT_BITS),
        .PAGE_BITS    (PAGE_BITS),
        .FRAME_BITS   (FRAME_BITS),
        .CNT_W        (CNT_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .policy_lru    (policy_reg),
        .entries_limit (limit_reg),
        .kind          (kind),
        .asid          (asid),
        .segment       (segment),
        .page          (page),
        .frame_in      (frame_in),
        .hit           (hit),
        .frame_out     (frame_out),
        .replaced      (replaced),
        .used_entries  (used_entries)
    );

endmodule

`default_nettype wire

>>> sv/tlbfl_ctrl.sv
// controller state machine of the translation buffer
// depends on tlbfl_pkg
`default_nettype none

module tlbfl_ctrl
    import tlbfl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    output tlbfl_cmd_t       cmd,
    input  wire tlbfl_stat_t stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_FLUSH  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = stat.is_flush ? S_FLUSH : S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_RESP;
            end
            S_FLUSH:
            begin
                cmd.flush_step = 1'b1;
                if (stat.flush_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule

`default_nettype wire

>>> sv/tlbfl_dp.sv
// datapath of the translation buffer: entry store, age ranks, matching
// and result registers. depends on tlbfl_pkg
`default_nettype none

module tlbfl_dp
    import tlbfl_pkg::*;
#(
    parameter int TLB_DEPTH    = 16,
    parameter int PID_BITS     = 16,
    parameter int SEGMENT_BITS = 8,
    parameter int PAGE_BITS    = 10,
    parameter int FRAME_BITS   = 12,
    parameter int IW           = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1,
    parameter int CNT_W        = $clog2(TLB_DEPTH + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tlbfl_cmd_t              cmd,
    output tlbfl_stat_t                  stat,
    input  wire logic                    policy_lru,
    input  wire logic [LIMIT_BITS-1:0]   entries_limit,
    input  wire logic [1:0]              kind,
    input  wire logic [PID_BITS-1:0]     asid,
    input  wire logic [SEGMENT_BITS-1:0] segment,
    input  wire logic [PAGE_BITS-1:0]    page,
    input  wire logic [FRAME_BITS-1:0]   frame_in,
    output logic                         hit,
    output logic [FRAME_BITS-1:0]        frame_out,
    output logic                         replaced,
    output logic [CNT_W-1:0]             used_entries
);

    logic [1:0]              kind_reg;
    logic [PID_BITS-1:0]     pid_reg;
    logic [SEGMENT_BITS-1:0] seg_reg;
    logic [PAGE_BITS-1:0]    page_reg;
    logic [FRAME_BITS-1:0]   frin_reg;

    logic [TLB_DEPTH-1:0]    valid_reg;
    logic [PID_BITS-1:0]     epid_reg   [TLB_DEPTH];
    logic [SEGMENT_BITS-1:0] eseg_reg   [TLB_DEPTH];
    logic [PAGE_BITS-1:0]    epage_reg  [TLB_DEPTH];
    logic [FRAME_BITS-1:0]   eframe_reg [TLB_DEPTH];
    logic [IW-1:0]           rank_reg   [TLB_DEPTH];
    logic [CNT_W-1:0]        count_reg;

    logic          hit_found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [IW-1:0] free_idx_reg;
    logic          old_found_reg;
    logic [IW-1:0] old_idx_reg;
    logic [IW-1:0] fidx_reg;

    logic                  hit_reg;
    logic [FRAME_BITS-1:0] frame_out_reg;
    logic                  replaced_reg;

    logic          hit_any;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] free_idx;
    logic          old_any;
    logic [IW-1:0] old_idx;
    logic [CNT_W-1:0] limit_eff;

    // update decode
    logic          upd_newest;
    logic [IW-1:0] upd_slot;
    logic          upd_write_key;
    logic          upd_write_frame;
    logic          upd_alloc;
    logic          upd_replace;
    logic          flush_drop;

    assign limit_eff = (int'(entries_limit) > TLB_DEPTH) ? CNT_W'(TLB_DEPTH)
                                                         : CNT_W'(entries_limit);

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        old_any  = 1'b0;
        old_idx  = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && epid_reg[i] == pid_reg && eseg_reg[i] == seg_reg &&
                epage_reg[i] == page_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
            if (valid_reg[i] && rank_reg[i] == '0)
            begin
                old_any = 1'b1;
                old_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        upd_newest      = 1'b0;
        upd_slot        = hit_idx_reg;
        upd_write_key   = 1'b0;
        upd_write_frame = 1'b0;
        upd_alloc       = 1'b0;
        upd_replace     = 1'b0;
        if (cmd.update)
        begin
            case (kind_reg)
                KIND_LOOKUP:
                begin
                    upd_newest = hit_found_reg && policy_lru;
                end
                KIND_FILL:
                begin
                    if (limit_eff != '0)
                    begin
                        if (hit_found_reg)
                        begin
                            upd_write_frame = 1'b1;
                            upd_newest      = 1'b1;
                        end
                        else if (count_reg < limit_eff)
                        begin
                            upd_slot        = free_idx_reg;
                            upd_write_key   = 1'b1;
                            upd_write_frame = 1'b1;
                            upd_alloc       = 1'b1;
                        end
                        else if (old_found_reg)
                        begin
                            upd_slot        = old_idx_reg;
                            upd_write_key   = 1'b1;
                            upd_write_frame = 1'b1;
                            upd_newest      = 1'b1;
                            upd_replace     = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign flush_drop = cmd.flush_step && valid_reg[fidx_reg] &&
                        ((kind_reg == KIND_FLUSH_PID && epid_reg[fidx_reg] == pid_reg) ||
                         (kind_reg == KIND_FLUSH_FRAME && eframe_reg[fidx_reg] == frin_reg));

    // payload, match index and entry store registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            pid_reg  <= asid;
            seg_reg  <= segment;
            page_reg <= page;
            frin_reg <= frame_in;
        end
        if (cmd.match)
        begin
            hit_idx_reg  <= hit_idx;
            free_idx_reg <= free_idx;
            old_idx_reg  <= old_idx;
        end
        if (upd_write_key)
        begin
            epid_reg[upd_slot]  <= pid_reg;
            eseg_reg[upd_slot]  <= seg_reg;
            epage_reg[upd_slot] <= page_reg;
        end
        if (upd_write_frame)
        begin
            eframe_reg[upd_slot] <= frin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            hit_found_reg <= 1'b0;
            old_found_reg <= 1'b0;
            fidx_reg      <= '0;
            hit_reg       <= 1'b0;
            frame_out_reg <= '0;
            replaced_reg  <= 1'b0;
            for (int i = 0; i < TLB_DEPTH; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.latch)
            begin
                hit_reg       <= 1'b0;
                frame_out_reg <= '0;
                replaced_reg  <= 1'b0;
                fidx_reg      <= '0;
            end
            if (cmd.match)
            begin
                hit_found_reg <= hit_any;
                old_found_reg <= old_any;
            end
            if (cmd.update && kind_reg == KIND_LOOKUP && hit_found_reg)
            begin
                hit_reg       <= 1'b1;
                frame_out_reg <= eframe_reg[hit_idx_reg];
            end
            if (upd_replace)
            begin
                replaced_reg <= 1'b1;
            end
            if (upd_newest)
            begin
                for (int i = 0; i < TLB_DEPTH; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] > rank_reg[upd_slot])
                    begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
                rank_reg[upd_slot] <= IW'(count_reg - 1'b1);
            end
            if (upd_alloc)
            begin
                valid_reg[upd_slot] <= 1'b1;
                rank_reg[upd_slot]  <= IW'(count_reg);
                count_reg           <= count_reg + 1'b1;
            end
            if (cmd.flush_step)
            begin
                fidx_reg <= fidx_reg + 1'b1;
            end
            if (flush_drop)
            begin
                for (int i = 0; i < TLB_DEPTH; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] > rank_reg[fidx_reg])
                    begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
                valid_reg[fidx_reg] <= 1'b0;
                rank_reg[fidx_reg]  <= '0;
                count_reg           <= count_reg - 1'b1;
            end
        end
    end

    assign stat.is_flush   = kind_reg[1];
    assign stat.flush_last = (fidx_reg == IW'(TLB_DEPTH - 1));

    assign hit          = hit_reg;
    assign frame_out    = frame_out_reg;
    assign replaced     = replaced_reg;
    assign used_entries = count_reg;

endmodule

`default_nettype wire

>>> sv/tlbfl_checker.sv
// port-level checks for the translation buffer, bound to the top level
// depends on tlb_with_fifo_lru_replacement
`default_nettype none

module tlbfl_checker #(
    parameter int TLB_DEPTH = 16,
    parameter int CNT_W     = 5
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic             hit,
    input wire logic             replaced,
    input wire logic [CNT_W-1:0] used_entries
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result transfer while idle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result transfer");

    a_hit_repl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && replaced))
        else $error("hit and replaced together");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        int'(used_entries) <= TLB_DEPTH)
        else $error("entry count above depth");

endmodule

bind tlb_with_fifo_lru_replacement tlbfl_checker #(
    .TLB_DEPTH (TLB_DEPTH),
    .CNT_W     (CNT_W)
) u_tlbfl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .replaced     (replaced),
    .used_entries (used_entries)
);

`default_nettype wire

>>> test/tb_tlb_with_fifo_lru_replacement.sv
// testbench for tlb_with_fifo_lru_replacement: directed and random lookup, fill and
// flush items checked against an in-bench translation buffer model
// depends on tlbfl_pkg and the tlb_with_fifo_lru_replacement rtl
`default_nettype none

module tb_tlb_with_fifo_lru_replacement;
    import tlbfl_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

    typedef struct packed {
        logic        hit;
        logic [11:0] frame;
        logic        replaced;
        logic [4:0]  used;
    } tlb_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [15:0] asid;
    logic [7:0]  segment;
    logic [9:0]  page;
    logic [11:0] frame_in;
    logic        done;
    logic        hit;
    logic [11:0] frame_out;
    logic        replaced;
    logic [4:0]  used_entries;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [4:0]  cfg_data;

    tlb_with_fifo_lru_replacement DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .asid(asid), .segment(segment), .page(page), .frame_in(frame_in),
        .done(done), .hit(hit), .frame_out(frame_out), .replaced(replaced),
        .used_entries(used_entries), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // translation buffer model
    logic        lru_mode;
    logic [4:0]  limit_reg;
    logic        slot_valid [DEPTH];
    logic [15:0] slot_pid   [DEPTH];
    logic [7:0]  slot_seg   [DEPTH];
    logic [9:0]  slot_page  [DEPTH];
    logic [11:0] slot_frame [DEPTH];
    int          slot_rank  [DEPTH];
    int          slot_count;

    tlb_result_t pending_results[$];
    int          error_count;
    int          cycle_count;
    int          idle_pct;

    logic [15:0] pool_pid   [6];
    logic [7:0]  pool_seg   [24];
    logic [9:0]  pool_page  [24];
    logic [15:0] pool_kpid  [24];
    logic [11:0] pool_frame [8];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[tlb_with_fifo_lru_replacement] ERROR");
            $finish;
        end
    end

    function automatic int find_slot(logic [15:0] p, logic [7:0] s, logic [9:0] g);
        for (int i = 0; i < DEPTH; i++)
            if (slot_valid[i] && slot_pid[i] == p && slot_seg[i] == s && slot_page[i] == g)
                return i;
        return -1;
    endfunction

    function automatic void make_youngest(int s);
        int r;
        r = slot_rank[s];
        for (int i = 0; i < DEPTH; i++)
            if (slot_valid[i] && slot_rank[i] > r)
                slot_rank[i]--;
        slot_rank[s] = slot_count - 1;
    endfunction

    function automatic void drop_slot(int s);
        int r;
        r = slot_rank[s];
        slot_valid[s] = 1'b0;
        slot_rank[s] = 0;
        for (int i = 0; i < DEPTH; i++)
            if (slot_valid[i] && slot_rank[i] > r)
                slot_rank[i]--;
        slot_count--;
    endfunction

    function automatic void predict_translation(logic [1:0] k, logic [15:0] p, logic [7:0] s,
                                                logic [9:0] g, logic [11:0] f);
        tlb_result_t res;
        int lim;
        int idx;
        res = '0;
        lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
        if (k == KIND_LOOKUP)
        begin
            idx = find_slot(p, s, g);
            if (idx >= 0)
            begin
                res.hit = 1'b1;
                res.frame = slot_frame[idx];
                if (lru_mode)
                    make_youngest(idx);
            end
        end
        else if (k == KIND_FILL)
        begin
            if (lim > 0)
            begin
                idx = find_slot(p, s, g);
                if (idx >= 0)
                begin
                    slot_frame[idx] = f;
                    make_youngest(idx);
                end
                else
                begin
                    idx = -1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (slot_count < lim ? !slot_valid[i]
                                             : (slot_valid[i] && slot_rank[i] == 0))
                            idx = i;
                    if (idx >= 0)
                    begin
                        slot_pid[idx] = p;
                        slot_seg[idx] = s;
                        slot_page[idx] = g;
                        slot_frame[idx] = f;
                        if (slot_count < lim)
                        begin
                            slot_valid[idx] = 1'b1;
                            slot_rank[idx] = slot_count;
                            slot_count++;
                        end
                        else
                        begin
                            make_youngest(idx);
                            res.replaced = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
                if (slot_valid[i] && ((k == KIND_FLUSH_PID && slot_pid[i] == p) ||
                                      (k == KIND_FLUSH_FRAME && slot_frame[i] == f)))
                    drop_slot(i);
        end
        res.used = slot_count[4:0];
        pending_results.push_back(res);
    endfunction

    always @(posedge clk)
    begin
        tlb_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b frame=%h replaced=%0b used=%0d",
                         $time, hit, frame_out, replaced, used_entries);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                    error_count++;
                end
                if (frame_out !== want.frame)
                begin
                    $display("%0t: frame_out expected %h actual %h", $time, want.frame,
                             frame_out);
                    error_count++;
                end
                if (replaced !== want.replaced)
                begin
                    $display("%0t: replaced expected %0b actual %0b", $time, want.replaced,
                             replaced);
                    error_count++;
                end
                if (used_entries !== want.used)
                begin
                    $display("%0t: used_entries expected %0d actual %0d", $time, want.used,
                             used_entries);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(logic [1:0] k, logic [15:0] p, logic [7:0] s, logic [9:0] g,
                             logic [11:0] f);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        kind = k;
        asid = p;
        segment = s;
        page = g;
        frame_in = f;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_translation(k, p, s, g, f);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_POLICY_LRU)
            lru_mode = value[0];
        else
            limit_reg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(logic lru, logic [4:0] lim);
        wait_idle();
        write_reg(CFG_POLICY_LRU, {4'd0, lru});
        write_reg(CFG_ENTRIES_LIMIT, lim);
    endtask

    task automatic random_items(int n);
        int pick;
        int ki;
        logic [1:0] k;
        logic [15:0] p;
        logic [7:0] s;
        logic [9:0] g;
        logic [11:0] f;
        for (int i = 0; i < n; i++)
        begin
            ki = $urandom_range(99);
            k = (ki < 45) ? KIND_LOOKUP : (ki < 86) ? KIND_FILL :
                (ki < 93) ? KIND_FLUSH_PID : KIND_FLUSH_FRAME;
            pick = $urandom_range(23);
            if ($urandom_range(99) < 85)
            begin
                p = pool_kpid[pick];
                s = pool_seg[pick];
                g = pool_page[pick];
            end
            else
            begin
                p = 16'($urandom);
                s = 8'($urandom);
                g = 10'($urandom);
            end
            f = ($urandom_range(99) < 70) ? pool_frame[$urandom_range(7)] : 12'($urandom);
            send_item(k, p, s, g, f);
        end
    endtask

    task automatic test_directed_cases();
        idle_pct = 0;
        send_item(KIND_LOOKUP, 16'h0000, 8'h00, 10'h000, 12'h000);
        send_item(KIND_FILL, 16'hffff, 8'hff, 10'h3ff, 12'hfff);
        send_item(KIND_LOOKUP, 16'hffff, 8'hff, 10'h3ff, 12'h000);
        send_item(KIND_FILL, 16'hffff, 8'hff, 10'h3ff, 12'h5a5);
        send_item(KIND_LOOKUP, 16'hffff, 8'hff, 10'h3ff, 12'h000);
        send_item(KIND_FILL, 16'h0000, 8'h00, 10'h000, 12'h000);
        send_item(KIND_FLUSH_PID, 16'h1234, 8'h00, 10'h000, 12'h000);
        send_item(KIND_FLUSH_FRAME, 16'h0000, 8'h00, 10'h000, 12'h5a5);
        send_item(KIND_FLUSH_PID, 16'h0000, 8'hff, 10'h3ff, 12'hfff);
        for (int i = 0; i < 6; i++)
            send_item(KIND_FILL, 16'h00a0, 8'(i), 10'(i), 12'(i + 1));
        // limit lowered below the count, then disabled
        configure(1'b0, 5'd3);
        send_item(KIND_FILL, 16'h00b0, 8'h01, 10'h001, 12'h0b0);
        send_item(KIND_LOOKUP, 16'h00a0, 8'h00, 10'h000, 12'h000);
        configure(1'b0, 5'd0);
        send_item(KIND_FILL, 16'h00c0, 8'h02, 10'h002, 12'h0c0);
        send_item(KIND_LOOKUP, 16'h00c0, 8'h02, 10'h002, 12'h000);
        configure(1'b1, 5'd31);
        send_item(KIND_FLUSH_PID, 16'h00a0, 8'h00, 10'h000, 12'h000);
    endtask

    task automatic test_fifo_replacement();
        configure(1'b0, 5'd16);
        idle_pct = 9;
        random_items(400);
    endtask

    task automatic test_lru_replacement();
        configure(1'b1, 5'd16);
        idle_pct = 87;
        random_items(300);
    endtask

    task automatic test_entry_limits();
        logic [4:0] limits [6] = '{5'd1, 5'd2, 5'd5, 5'd0, 5'd31, 5'd8};
        idle_pct = 0;
        for (int i = 0; i < 6; i++)
        begin
            configure(1'(i), limits[i]);
            idle_pct = 0;
            random_items(90);
        end
    endtask

    task automatic test_full_depth_mix();
        configure(1'b1, 5'd16);
        idle_pct = 0;
        random_items(380);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_LOOKUP;
        asid = '0;
        segment = '0;
        page = '0;
        frame_in = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POLICY_LRU;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        lru_mode = 1'b0;
        limit_reg = 5'(LIMIT_RESET);
        slot_count = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_rank[i] = 0;
            slot_pid[i] = '0;
            slot_seg[i] = '0;
            slot_page[i] = '0;
            slot_frame[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            pool_pid[i] = 16'($urandom);
        for (int i = 0; i < 24; i++)
        begin
            pool_kpid[i] = pool_pid[$urandom_range(5)];
            pool_seg[i] = 8'($urandom);
            pool_page[i] = 10'($urandom);
        end
        for (int i = 0; i < 8; i++)
            pool_frame[i] = 12'($urandom);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_fifo_replacement();
        test_lru_replacement();
        test_entry_limits();
        test_full_depth_mix();

        wait_idle();
        if (error_count == 0)
            $display("[tlb_with_fifo_lru_replacement] OK");
        else
            $display("[tlb_with_fifo_lru_replacement] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
sv/tlbfl_pkg.sv
sv/tlbfl_ctrl.sv
sv/tlbfl_dp.sv
sv/tlb_with_fifo_lru_replacement.sv
sv/tlbfl_checker.sv
test/tb_tlb_with_fifo_lru_replacement.sv
